// File: rtl/iwt_pkg.sv
// iwt_pkg: shared types and constants of the idle connection timeout wheel
// no dependencies; used by iwt_cell and idle_connection_timeout_wheel
package iwt_pkg;

  localparam int unsigned MaxConnDefault    = 32;
  localparam int unsigned WheelSlotsDefault = 4;

  localparam int unsigned OpW    = 2;
  localparam int unsigned IdW    = 5;
  localparam int unsigned TicksW = 3;
  localparam int unsigned InDataW  = 8;  // op + conn_id, padded to a byte
  localparam int unsigned OutDataW = 8;  // timed_out_id, padded to a byte

  typedef enum logic [OpW-1:0] {
    OP_ACTIVITY = 2'd0,
    OP_TICK     = 2'd1,
    OP_CLOSE    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  // command broadcast to every cell
  typedef struct packed {
    logic activity;
    logic close;
    logic tick;
    logic shift;
  } cell_cmd_t;

endpackage

// File: rtl/idle_connection_timeout_wheel.sv
// idle connection timeout wheel: row of per-connection cells and the tick drain control
// depends on iwt_pkg and iwt_cell
// activity and close requests give no result; a new one each cycle while no tick is draining
// a tick holds off requests until its drain ends, and longer under output back-pressure:
// all cells update at once, then the expiry flags shift down the cell chain one id per
// cycle, unless a held result waits on a full output
// asynchronous active-low reset untracks every connection and empties the output
module idle_connection_timeout_wheel #(
  parameter int unsigned MAX_CONN    = iwt_pkg::MaxConnDefault,
  parameter int unsigned WHEEL_SLOTS = iwt_pkg::WheelSlotsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request side
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [iwt_pkg::InDataW-1:0]   s_axis_tdata,   // op[1:0], conn_id[6:2], zero pad
  // result side
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [iwt_pkg::OutDataW-1:0]  m_axis_tdata,   // timed_out_id[4:0], zero pad
  output logic                          m_axis_tuser,   // found
  output logic                          m_axis_tlast    // last result of this tick
);

  localparam int unsigned CntW = (MAX_CONN > 1) ? $clog2(MAX_CONN) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(MAX_CONN - 1);

  // request decode
  logic                        req_acc;
  logic [iwt_pkg::OpW-1:0]     req_op;
  logic [iwt_pkg::IdW-1:0]     req_id;
  logic [31:0]                 req_id_wide;

  assign req_acc     = s_axis_tvalid && s_axis_tready;
  assign req_op      = s_axis_tdata[iwt_pkg::OpW-1:0];
  assign req_id      = s_axis_tdata[iwt_pkg::OpW +: iwt_pkg::IdW];
  assign req_id_wide = 32'(req_id);

  // drain control state
  iwt_pkg::state_e     state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [CntW-1:0]     pend_id_q, pend_id_d;
  logic                pend_vld_q, pend_vld_d;

  // result register
  logic                        out_vld_q, out_vld_d;
  logic [iwt_pkg::IdW-1:0]     out_id_q, out_id_d;
  logic                        out_found_q, out_found_d;
  logic                        out_last_q, out_last_d;

  iwt_pkg::cell_cmd_t cmd;
  logic [MAX_CONN-1:0] exp_flag;
  logic [MAX_CONN:0]   exp_chain;
  logic                out_free;
  logic [31:0]         pend_id_wide;

  assign out_free     = !out_vld_q || m_axis_tready;
  assign pend_id_wide = 32'(pend_id_q);

  // cell chain: expiry flags move one cell down per scan step, cell 0 is the head
  assign exp_chain[MAX_CONN] = 1'b0;

  for (genvar i = 0; i < MAX_CONN; i++) begin : g_cell
    logic hit;
    // ids at or beyond MAX_CONN match no cell
    assign hit = (req_id_wide == i);
    iwt_cell #(
      .WHEEL_SLOTS(WHEEL_SLOTS)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .hit_i     (hit),
      .exp_next_i(exp_chain[i+1]),
      .exp_o     (exp_flag[i])
    );
    assign exp_chain[i] = exp_flag[i];
  end

  assign s_axis_tready = (state_q == iwt_pkg::ST_IDLE);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pend_id_d   = pend_id_q;
    pend_vld_d  = pend_vld_q;
    out_vld_d   = out_vld_q && !m_axis_tready;
    out_id_d    = out_id_q;
    out_found_d = out_found_q;
    out_last_d  = out_last_q;

    cmd.activity = req_acc && (req_op == iwt_pkg::OP_ACTIVITY);
    cmd.close    = req_acc && (req_op == iwt_pkg::OP_CLOSE);
    cmd.tick     = req_acc && (req_op == iwt_pkg::OP_TICK);
    cmd.shift    = 1'b0;

    unique case (state_q)
      iwt_pkg::ST_IDLE: begin
        if (cmd.tick) begin
          state_d    = iwt_pkg::ST_SCAN;
          cnt_d      = '0;
          pend_vld_d = 1'b0;
        end
      end
      iwt_pkg::ST_SCAN: begin
        // the newest expiry is held back so the final one can carry last
        if (exp_flag[0] && pend_vld_q) begin
          if (out_free) begin
            out_vld_d   = 1'b1;
            out_id_d    = pend_id_wide[iwt_pkg::IdW-1:0];
            out_found_d = 1'b1;
            out_last_d  = 1'b0;
            cmd.shift   = 1'b1;
          end
        end else begin
          cmd.shift = 1'b1;
        end
        if (cmd.shift) begin
          if (exp_flag[0]) begin
            pend_id_d  = cnt_q;
            pend_vld_d = 1'b1;
          end
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == CntLast) begin
            state_d = iwt_pkg::ST_FLUSH;
          end
        end
      end
      iwt_pkg::ST_FLUSH: begin
        if (out_free) begin
          out_vld_d   = 1'b1;
          out_id_d    = pend_vld_q ? pend_id_wide[iwt_pkg::IdW-1:0] : '0;
          out_found_d = pend_vld_q;
          out_last_d  = 1'b1;
          state_d     = iwt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = iwt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= iwt_pkg::ST_IDLE;
      cnt_q      <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    pend_id_q   <= pend_id_d;
    out_id_q    <= out_id_d;
    out_found_q <= out_found_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(iwt_pkg::OutDataW - iwt_pkg::IdW){1'b0}}, out_id_q};
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// File: rtl/iwt_cell.sv
// iwt_cell: one connection slot of the wheel, with its expiry flag in the drain chain
// depends on iwt_pkg
module iwt_cell #(
  parameter int unsigned WHEEL_SLOTS = iwt_pkg::WheelSlotsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  iwt_pkg::cell_cmd_t cmd_i,
  input  logic              hit_i,       // request addresses this cell
  input  logic              exp_next_i,  // expiry flag of the next cell up
  output logic              exp_o
);

  localparam logic [iwt_pkg::TicksW-1:0] Reload = iwt_pkg::TicksW'(WHEEL_SLOTS - 1);

  logic                        tracked_q, tracked_d;
  logic                        seen_q, seen_d;
  logic [iwt_pkg::TicksW-1:0]  ticks_q, ticks_d;
  logic                        exp_q, exp_d;

  always_comb begin
    tracked_d = tracked_q;
    seen_d    = seen_q;
    ticks_d   = ticks_q;
    exp_d     = exp_q;
    if (cmd_i.activity && hit_i) begin
      if (tracked_q) begin
        seen_d = 1'b1;
      end else begin
        tracked_d = 1'b1;
        seen_d    = 1'b0;
        ticks_d   = Reload;
      end
    end else if (cmd_i.close && hit_i) begin
      tracked_d = 1'b0;
      seen_d    = 1'b0;
      ticks_d   = '0;
    end else if (cmd_i.tick) begin
      exp_d = 1'b0;
      if (tracked_q) begin
        if (ticks_q != '0) begin
          ticks_d = ticks_q - 1'b1;
        end else if (seen_q) begin
          seen_d  = 1'b0;
          ticks_d = Reload;
        end else begin
          tracked_d = 1'b0;
          seen_d    = 1'b0;
          ticks_d   = '0;
          exp_d     = 1'b1;
        end
      end
    end else if (cmd_i.shift) begin
      exp_d = exp_next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tracked_q <= 1'b0;
      seen_q    <= 1'b0;
      ticks_q   <= '0;
      exp_q     <= 1'b0;
    end else begin
      tracked_q <= tracked_d;
      seen_q    <= seen_d;
      ticks_q   <= ticks_d;
      exp_q     <= exp_d;
    end
  end

  assign exp_o = exp_q;

endmodule
